### design/b64c_pkg.sv
// Package: shared constants, job descriptor type and alphabet helpers for the Base64 codec.
`timescale 1ns / 1ps
package b64c_pkg;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='
  localparam logic [7:0] BAD_IDX  = 8'hFF;

  localparam int QUEUE_DEPTH = 2;

  // one input word's worth of results, up to four
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [1:0]      last_idx;  // number of results minus one
    logic            byte_ok;   // low only for the bare end marker
    logic            frame_end;
  } b64c_job_t;

  function automatic logic [7:0] alpha_char(input logic [5:0] idx);
    logic [7:0] r;
    r = 8'h2F;  // '/'
    if (idx < 6'd26)      r = 8'({2'b00, idx}) + 8'd65;
    else if (idx < 6'd52) r = 8'({2'b00, idx}) + 8'd71;
    else if (idx < 6'd62) r = 8'({2'b00, idx}) - 8'd4;
    else if (idx == 6'd62) r = 8'h2B;  // '+'
    return r;
  endfunction

  function automatic logic [7:0] char_index(input logic [7:0] c);
    logic [7:0] r;
    r = BAD_IDX;
    if (c inside {[8'h41:8'h5A]})      r = c - 8'h41;
    else if (c inside {[8'h61:8'h7A]}) r = c - 8'd71;
    else if (c inside {[8'h30:8'h39]}) r = c + 8'd4;
    else if (c == 8'h2B)               r = 8'd62;
    else if (c == 8'h2F)               r = 8'd63;
    return r;
  endfunction

endpackage

### design/base64_codec_top.sv
// Top level of the streaming Base64 codec: front end, job queue and back end.
//
// Usage:
//  - cfg_we/cfg_wdata write the direction (0 encode, 1 decode) and drop any
//    half-built group. Write only while the codec is idle.
//  - Input stream in_*: one byte or character per word, in_tlast on the final
//    word of a stream. Output stream out_*: one character or byte per word.
//    out_tuser[0] is low only on the bare end marker a decode stream gives
//    when its last word yields no byte; out_tuser[1] flags the last result of
//    an input word; out_tlast flags the final result of the stream.
//  - A word's results pass a queue slot and the back end job register before
//    out_tvalid shows them. Each input word yields at most four results.
//  - Throughput: the output side moves one word per cycle while out_tready is
//    high. Encoding gives four characters per group of three words, decoding
//    takes up to one word per cycle; the output port sets both.
//  - A two-entry job queue (QUEUE_DEPTH) sits between the front and back end,
//    so input keeps flowing while a result waits on out_tready. When the
//    queue fills, in_tready drops until the back end frees an entry.
//  - Reset (rst_n low, synchronous) empties the queue, drops the word in
//    flight and sets the direction back to encode.
`timescale 1ns / 1ps
module base64_codec_top
  import b64c_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_we,
  input  logic       cfg_wdata,   // direction
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] in_byte
  input  logic       in_tlast,
  // output stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic [1:0] out_tuser,   // [0] byte_valid, [1] run_last
  output logic       out_tlast    // stream_end
);

  logic      acc;
  logic      push, pop;
  logic      q_valid, q_full;
  b64c_job_t push_job, q_job;

  // front only stalls on a full queue
  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  b64c_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .push      (push),
    .job       (push_job)
  );

  b64c_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .q_job    (q_job)
  );

  b64c_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### design/b64c_front.sv
// Front end: accepts words, keeps group state, pushes a job when a word yields results.
`timescale 1ns / 1ps
module b64c_front
  import b64c_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       acc,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       push,
  output b64c_job_t  job
);

  logic            dir_r, dir_nxt;
  logic [2:0][7:0] grp_r, grp_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            pad_r, pad_nxt;

  // encode path
  logic [1:0]      e_n;
  logic [2:0]      e_n1;
  logic [2:0][7:0] e_grp;
  logic [7:0]      e_g1, e_g2;
  logic [3:0][5:0] e_s;
  logic            e_fire;
  logic [3:0][7:0] e_chars;

  // decode path
  logic            d_is_pad, d_emit, d_store;
  logic [7:0]      d_v, d_a3;
  logic [2:0][7:0] d_grp;
  logic [2:0][7:0] d_b;
  logic [1:0]      d_n;

  always_comb begin
    e_n = (cnt_r > 2'd2) ? 2'd0 : cnt_r;
    e_grp = grp_r;
    e_grp[e_n] = in_byte;
    e_n1 = {1'b0, e_n} + 3'd1;
    e_fire = (e_n1 == 3'd3) || in_last;
    e_g1 = (e_n1 > 3'd1) ? e_grp[1] : 8'd0;
    e_g2 = (e_n1 > 3'd2) ? e_grp[2] : 8'd0;
    e_s[0] = e_grp[0][7:2];
    e_s[1] = {e_grp[0][1:0], e_g1[7:4]};
    e_s[2] = {e_g1[3:0], e_g2[7:6]};
    e_s[3] = e_g2[5:0];
    for (int j = 0; j < 4; j++) begin
      e_chars[j] = (3'(j) <= e_n1) ? alpha_char(e_s[j]) : PAD_CHAR;
    end
  end

  always_comb begin
    d_is_pad = (in_byte == PAD_CHAR);
    d_v      = char_index(in_byte);
    d_emit   = !pad_r && !d_is_pad && (cnt_r == 2'd3);
    d_store  = !pad_r && !d_is_pad && (cnt_r != 2'd3);
    d_grp    = grp_r;
    if (d_store) begin
      d_grp[cnt_r] = d_v;
    end
    d_a3 = d_emit ? d_v : BAD_IDX;
    // bytes wrap at 8 bits, invalid indices included
    d_b[0] = 8'({d_grp[0], 2'b00}) + {6'd0, d_grp[1][5:4]};
    d_b[1] = {d_grp[1][3:0], 4'd0} + {4'd0, d_grp[2][5:2]};
    d_b[2] = {d_grp[2][1:0], 6'd0} + d_a3;
    if (d_emit) begin
      d_n = 2'd3;
    end else if (!pad_r && d_is_pad) begin
      d_n = (cnt_r >= 2'd2) ? cnt_r - 2'd1 : 2'd0;
    end else if (d_store && in_last) begin
      d_n = cnt_r;  // partial group of cnt+1 indices gives cnt bytes
    end else begin
      d_n = 2'd0;
    end
  end

  always_comb begin
    dir_nxt = dir_r;
    grp_nxt = grp_r;
    cnt_nxt = cnt_r;
    pad_nxt = pad_r;
    push    = 1'b0;
    job     = '0;
    job.frame_end = in_last;
    job.byte_ok   = 1'b1;
    if (cfg_we) begin
      dir_nxt = cfg_wdata;
      grp_nxt = '0;
      cnt_nxt = 2'd0;
      pad_nxt = 1'b0;
    end else if (acc) begin
      if (dir_r == DIR_ENCODE) begin
        grp_nxt = e_grp;
        cnt_nxt = e_fire ? 2'd0 : e_n1[1:0];
        push = e_fire;
        job.data = e_chars;
        job.last_idx = 2'd3;
      end else begin
        grp_nxt = d_grp;
        if (d_emit || (!pad_r && d_is_pad)) begin
          cnt_nxt = 2'd0;
        end else if (d_store) begin
          cnt_nxt = cnt_r + 2'd1;
        end
        if (!pad_r && d_is_pad) begin
          pad_nxt = 1'b1;
        end
        if (d_n != 2'd0) begin
          push = 1'b1;
          job.data = {8'd0, d_b};
          job.last_idx = d_n - 2'd1;
        end else if (in_last) begin
          push = 1'b1;
          job.byte_ok = 1'b0;
        end
      end
      if (in_last) begin
        grp_nxt = '0;
        cnt_nxt = 2'd0;
        pad_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_ENCODE;
      grp_r <= '0;
      cnt_r <= 2'd0;
      pad_r <= 1'b0;
    end else begin
      dir_r <= dir_nxt;
      grp_r <= grp_nxt;
      cnt_r <= cnt_nxt;
      pad_r <= pad_nxt;
    end
  end

endmodule

### design/b64c_queue.sv
// Job queue: small register FIFO between front and back end.
`timescale 1ns / 1ps
module b64c_queue
  import b64c_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH  // at least 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  b64c_job_t push_job,
  input  logic      pop,
  output logic      q_valid,
  output logic      q_full,
  output b64c_job_t q_job
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  b64c_job_t         slot_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  assign q_valid = (cnt_r != '0);
  assign q_full  = (cnt_r == CW'(DEPTH));
  assign q_job   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### design/b64c_back.sv
// Back end: plays out one job a word per cycle on the output stream while out_tready is high.
`timescale 1ns / 1ps
module b64c_back
  import b64c_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  b64c_job_t  q_job,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic [1:0] out_tuser,
  output logic       out_tlast
);

  b64c_job_t  cur_r, cur_nxt;
  logic       busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       at_end, fire, done;

  assign at_end = (idx_r == cur_r.last_idx);
  assign fire   = busy_r && out_tready;
  assign done   = fire && at_end;
  assign pop    = q_valid && (!busy_r || done);

  assign out_tvalid = busy_r;
  assign out_tdata  = cur_r.data[idx_r];
  assign out_tuser  = {at_end, cur_r.byte_ok};
  assign out_tlast  = at_end && cur_r.frame_end;

  always_comb begin
    cur_nxt  = cur_r;
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (pop) begin
      cur_nxt  = q_job;
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (fire) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule
